[hw/rtl/u8sd_pkg.sv]
package u8sd_pkg;

    // Widths of the stream fields.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned PointW = 31;
    localparam int unsigned CountW = 3;

    // Longest sequence that a lead byte can announce.
    localparam logic [CountW-1:0] MaxSeqLen = 3'd6;

    // Largest code point kept in BMP mode.
    localparam logic [PointW-1:0] BmpMax = 31'h0000_FFFF;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [CountW-1:0] seq_length;
        logic [CountW-1:0] byte_position;
        logic [PointW-1:0] partial_value;
        logic              string_failed;
    } state_t;

    // One result item, plus a flag that says whether the byte made one.
    typedef struct packed {
        logic              emit;
        logic [PointW-1:0] code_point;
        logic              point_valid;
        logic              decode_error;
        logic              string_done;
    } result_t;

endpackage

[hw/rtl/utf8_stream_decoder_core.sv]
// Channel  | Signals                            | Contents
// ---------+------------------------------------+----------------------------------------
// s_axis   | tvalid, tready, tdata[7:0], tlast  | text_byte; tlast = end_flag
// m_axis   | tvalid, tready, tdata[31:0], tuser | code_point (bit 31 zero); tuser = flags
//          | [1:0], tlast                       | tlast = string_done
// cfg      | valid, ready, data[0]              | limit_to_bmp
//
// One byte per cycle sustained while results drain. A byte enters the input
// register, is decoded against the sequence state and moves into the result
// register when that register is free, where its result is offered until it
// is taken. Bytes that make no result leave no gap. The only stall is a full
// result register whose transfer is held by m_axis_tready. Reset clears the
// state, both valid flags and limit_to_bmp.
module utf8_stream_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata = text_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // Result stream: tdata = code_point[30:0], zero pad[31]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // tuser = point_valid[0], decode_error[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import u8sd_pkg::*;

    logic              limit_reg;
    logic              in_valid_reg;
    logic [ByteW-1:0]  in_byte_reg;
    logic              in_last_reg;
    state_t            state_reg;
    state_t            state_next;
    result_t           result;
    logic              out_valid_reg;
    logic [PointW-1:0] out_point_reg;
    logic              out_pvalid_reg;
    logic              out_error_reg;
    logic              out_done_reg;
    logic              out_free;
    logic              process;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || process;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= 1'b0;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Decode of the held byte.
    u8sd_step u_step (
        .text_byte    (in_byte_reg),
        .end_flag     (in_last_reg),
        .limit_to_bmp (limit_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .result       (result)
    );

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (process) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= process && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && result.emit) begin
            out_point_reg  <= result.code_point;
            out_pvalid_reg <= result.point_valid;
            out_error_reg  <= result.decode_error;
            out_done_reg   <= result.string_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_point_reg};
    assign m_axis_tuser  = {out_error_reg, out_pvalid_reg};
    assign m_axis_tlast  = out_done_reg;

`ifndef NO_ASSERTIONS
    // An open sequence is between two and six bytes long.
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seq_length != 3'd1 && state_reg.seq_length != 3'd7)
        else $error("sequence length out of range");

    // The byte count stays inside the open sequence, and zero when none is open.
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq_length == 3'd0) ? (state_reg.byte_position == 3'd0)
                                       : (state_reg.byte_position < state_reg.seq_length))
        else $error("byte position outside the open sequence");

    // A failed string holds no partial sequence.
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.string_failed |-> (state_reg.seq_length == 3'd0 &&
                                     state_reg.partial_value == '0))
        else $error("failed string kept sequence state");

    // An error is only reported on the transfer that closes the string.
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("error flag outside a closing result");

    // A result without a point carries a zero code point.
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("code point set without point_valid");
`endif

endmodule

[hw/rtl/u8sd_step.sv]
module u8sd_step (
    input  logic [u8sd_pkg::ByteW-1:0] text_byte,
    input  logic                       end_flag,
    input  logic                       limit_to_bmp,
    input  u8sd_pkg::state_t           state,
    output u8sd_pkg::state_t           state_next,
    output u8sd_pkg::result_t          result
);
    import u8sd_pkg::*;

    // Sequence length announced by a lead byte; zero for an invalid lead.
    function automatic logic [CountW-1:0] lead_length(input logic [ByteW-1:0] b);
        logic [CountW-1:0] len;
        begin
            priority if (b[7] == 1'b0)          len = 3'd1;
            else if (b[7:5] == 3'b110)          len = 3'd2;
            else if (b[7:4] == 4'b1110)         len = 3'd3;
            else if (b[7:3] == 5'b11110)        len = 3'd4;
            else if (b[7:2] == 6'b111110)       len = 3'd5;
            else if (b[7:1] == 7'b1111110)      len = MaxSeqLen;
            else                                len = 3'd0;
            return len;
        end
    endfunction

    // Payload bits of a lead byte for each sequence length.
    function automatic logic [ByteW-1:0] lead_mask(input logic [CountW-1:0] len);
        logic [ByteW-1:0] m;
        begin
            unique case (len)
                3'd2:    m = 8'h1F;
                3'd3:    m = 8'h0F;
                3'd4:    m = 8'h07;
                3'd5:    m = 8'h03;
                3'd6:    m = 8'h01;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

    // True when the third byte leaves the point overlong for its length.
    function automatic logic third_overlong(input logic [CountW-1:0] len,
                                            input logic [ByteW-1:0]  b);
        logic zero;
        begin
            unique case (len)
                3'd3:    zero = (b[6:4] == 3'd0);
                3'd4:    zero = (b[6:3] == 4'd0);
                3'd5:    zero = (b[6:2] == 5'd0);
                3'd6:    zero = (b[6:1] == 6'd0);
                3'd7:    zero = (b[6:0] == 7'd0);
                default: zero = 1'b0;
            endcase
            return zero;
        end
    endfunction

    logic [CountW-1:0] lead_len;
    logic [CountW-1:0] pos_inc;
    logic              have_point;
    logic              keep_point;
    logic [PointW-1:0] point;
    logic              err;
    state_t            st;

    assign lead_len = lead_length(text_byte);
    assign pos_inc  = state.byte_position + 3'd1;

    // Per-byte decode of a lead or continuation byte against the sequence state.
    always_comb
    begin
        st         = state;
        have_point = 1'b0;
        point      = '0;
        if (!state.string_failed) begin
            if (state.seq_length == 3'd0) begin
                if (lead_len == 3'd0 || (lead_len == 3'd2 && text_byte[4:1] == 4'd0)) begin
                    st.string_failed = 1'b1;
                end else if (lead_len == 3'd1) begin
                    have_point = 1'b1;
                    point      = {{(PointW-ByteW){1'b0}}, text_byte};
                end else begin
                    st.partial_value = {{(PointW-ByteW){1'b0}},
                                        text_byte & lead_mask(lead_len)};
                    st.seq_length    = lead_len;
                    st.byte_position = 3'd1;
                end
            end else begin
                if (text_byte[7:6] != 2'b10) begin
                    st.string_failed = 1'b1;
                end else if (state.byte_position == 3'd2 && state.partial_value == '0 &&
                             third_overlong(state.seq_length, text_byte)) begin
                    st.string_failed = 1'b1;
                end else begin
                    st.partial_value = {state.partial_value[PointW-7:0], text_byte[5:0]};
                    st.byte_position = pos_inc;
                    if (pos_inc >= state.seq_length) begin
                        have_point       = 1'b1;
                        point            = st.partial_value;
                        st.seq_length    = 3'd0;
                        st.byte_position = 3'd0;
                        st.partial_value = '0;
                    end
                end
            end
            if (st.string_failed) begin
                st.seq_length    = 3'd0;
                st.byte_position = 3'd0;
                st.partial_value = '0;
            end
        end
    end

    assign keep_point = have_point && !(limit_to_bmp && point > BmpMax);

    // Close the string on a terminator or a last byte, otherwise pass on a point that the BMP limit keeps.
    always_comb
    begin
        state_next = st;
        result     = '0;
        err        = 1'b0;
        if (text_byte == '0) begin
            err                 = state.string_failed || (state.seq_length != 3'd0);
            result.emit         = 1'b1;
            result.decode_error = err;
            result.string_done  = 1'b1;
            state_next          = '0;
        end else if (end_flag) begin
            err                 = st.string_failed || (st.seq_length != 3'd0);
            result.emit         = 1'b1;
            result.point_valid  = keep_point && !err;
            result.code_point   = (keep_point && !err) ? point : '0;
            result.decode_error = err;
            result.string_done  = 1'b1;
            state_next          = '0;
        end else if (keep_point) begin
            result.emit        = 1'b1;
            result.point_valid = 1'b1;
            result.code_point  = point;
        end
    end

endmodule
